// ===== hdl/tae_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tae_pkg
// Shared types and codes for the Thumb ALU execute block.
// ----------------------------------------------------------------------------
package tae_pkg;

  localparam int RegCount  = 16;
  localparam int RegAddrW  = 4;
  localparam int DataW     = 32;
  localparam int FlagW     = 4;

  // NZCV bit positions
  localparam int FlagN = 3;
  localparam int FlagZ = 2;
  localparam int FlagC = 1;
  localparam int FlagV = 0;

  typedef enum logic [3:0] {
    FUNC_BIC     = 4'd0,
    FUNC_SUBREG  = 4'd1,
    FUNC_SUBIMM  = 4'd2,
    FUNC_CMPIMM  = 4'd3,
    FUNC_LSL     = 4'd4,
    FUNC_LSR     = 4'd5,
    FUNC_ADDREG  = 4'd6,
    FUNC_ADDIMM  = 4'd7,
    FUNC_MOVIMM  = 4'd8,
    FUNC_MOVHIGH = 4'd9,
    FUNC_SBC     = 4'd10
  } func_t;

  typedef struct packed {
    logic [3:0]  func;
    logic [15:0] opcode_halfword;
  } instr_t;

  typedef struct packed {
    logic [RegAddrW-1:0] dest_index;
    logic [DataW-1:0]    dest_value;
    logic                wrote_register;
    logic [FlagW-1:0]    flags_out;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/thumb_alu_execute.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thumb_alu_execute
// Executes one Thumb data-processing instruction per beat against a
// 16-entry register file and the NZCV flags.
// ----------------------------------------------------------------------------
//  channel  | signals                              | payload
//  ---------+--------------------------------------+------------------------
//  instr    | instr_valid / instr_ready / instr    | func, opcode_halfword
//  result   | result_valid / result_ready / result | dest, value, write, NZCV
//
// One beat per cycle sustained while the result is not stalled; the register file
// is read on the beat edge, then execute writes the result register.
// Register file and flags are written as an instruction leaves execute;
// a same-cycle read of that entry is forwarded.
// Reset clears flags and per-entry valid bits; invalid entries read as zero.
// A stalled result holds execute; instr_ready drops only then.
// ----------------------------------------------------------------------------
module thumb_alu_execute
  import tae_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    instr_valid,
  output logic         instr_ready,
  input  wire instr_t  instr,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  // read address decode on the incoming beat
  logic [RegAddrW-1:0] raddr_a, raddr_b;
  logic [15:0]         iw;

  always_comb begin
    iw = instr.opcode_halfword;
    case (instr.func) inside
      FUNC_BIC, FUNC_SBC:         raddr_a = {1'b0, iw[2:0]};
      FUNC_SUBIMM, FUNC_CMPIMM:   raddr_a = {1'b0, iw[10:8]};
      FUNC_MOVHIGH:               raddr_a = iw[6:3];
      default:                    raddr_a = {1'b0, iw[5:3]};
    endcase
    case (instr.func) inside
      FUNC_BIC, FUNC_SBC: raddr_b = {1'b0, iw[5:3]};
      default:            raddr_b = {1'b0, iw[8:6]};
    endcase
  end

  // execute stage registers
  logic                 s1_valid;
  instr_t               s1_instr;
  logic                 byp_a, byp_b, vld_a, vld_b;
  logic [DataW-1:0]     fwd_data;
  logic [DataW-1:0]     ram_a, ram_b;
  logic [RegCount-1:0]  rf_valid;
  logic [FlagW-1:0]     flags;

  logic                 s1_move, accept;
  logic                 wr_en;
  logic [RegAddrW-1:0]  rd;
  logic [DataW-1:0]     val;
  logic                 wr;
  logic [FlagW-1:0]     flags_next;

  assign s1_move     = s1_valid && (!result_valid || result_ready);
  assign instr_ready = !s1_valid || s1_move;
  assign accept      = instr_valid && instr_ready;
  assign wr_en       = s1_move && wr;

  tae_ram #(
    .WIDTH (DataW),
    .DEPTH (RegCount)
  ) u_rf (
    .clk     (clk),
    .we      (wr_en),
    .waddr   (rd),
    .wdata   (val),
    .re      (accept),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (ram_a),
    .rdata_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_instr <= instr;
      byp_a    <= wr_en && (rd == raddr_a);
      byp_b    <= wr_en && (rd == raddr_b);
      vld_a    <= rf_valid[raddr_a];
      vld_b    <= rf_valid[raddr_b];
      fwd_data <= val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid <= '0;
      flags    <= '0;
    end else if (s1_move) begin
      flags <= flags_next;
      if (wr) begin
        rf_valid[rd] <= 1'b1;
      end
    end
  end

  // operands
  logic [DataW-1:0] opa, opb;
  logic [15:0]      w;
  logic [2:0]       lo0, lo3, lo6, hi8;
  logic [7:0]       imm8;
  logic [4:0]       imm5;

  assign opa  = byp_a ? fwd_data : (vld_a ? ram_a : '0);
  assign opb  = byp_b ? fwd_data : (vld_b ? ram_b : '0);
  assign w    = s1_instr.opcode_halfword;
  assign lo0  = w[2:0];
  assign lo3  = w[5:3];
  assign lo6  = w[8:6];
  assign hi8  = w[10:8];
  assign imm8 = w[7:0];
  assign imm5 = w[10:6];

  // shared adder: subtract is a + ~b + carry-in
  logic [DataW-1:0] add_b;
  logic             add_cin;
  logic [DataW:0]   sum;
  logic             add_v;

  always_comb begin
    add_b   = '0;
    add_cin = 1'b0;
    case (s1_instr.func) inside
      FUNC_SUBREG: begin
        add_b   = ~opb;
        add_cin = 1'b1;
      end
      FUNC_SUBIMM, FUNC_CMPIMM: begin
        add_b   = ~{24'd0, imm8};
        add_cin = 1'b1;
      end
      FUNC_ADDREG: add_b = opb;
      FUNC_ADDIMM: add_b = {29'd0, lo6};
      FUNC_SBC: begin
        add_b   = ~opb;
        add_cin = flags[FlagC];
      end
      default: ;
    endcase
    sum   = {1'b0, opa} + {1'b0, add_b} + {{DataW{1'b0}}, add_cin};
    add_v = ~(opa[DataW-1] ^ add_b[DataW-1]) & (opa[DataW-1] ^ sum[DataW-1]);
  end

  // shifter: 33-bit forms carry the last bit out
  logic [DataW:0] lsl_ext, lsr_ext;
  logic [5:0]     lsr_sh;

  assign lsl_ext = {1'b0, opa} << imm5;
  assign lsr_sh  = (imm5 == 5'd0) ? 6'd32 : {1'b0, imm5};
  assign lsr_ext = {opa, 1'b0} >> lsr_sh;

  // result and flags
  logic set_nz;

  always_comb begin
    rd         = '0;
    val        = '0;
    wr         = 1'b1;
    set_nz     = 1'b1;
    flags_next = flags;
    case (s1_instr.func) inside
      FUNC_BIC: begin
        rd  = {1'b0, lo0};
        val = opa & ~opb;
      end
      FUNC_SUBREG, FUNC_ADDREG, FUNC_ADDIMM, FUNC_SBC: begin
        rd  = {1'b0, lo0};
        val = sum[DataW-1:0];
        flags_next[FlagC] = sum[DataW];
        flags_next[FlagV] = add_v;
      end
      FUNC_SUBIMM: begin
        rd  = {1'b0, hi8};
        val = sum[DataW-1:0];
        flags_next[FlagC] = sum[DataW];
        flags_next[FlagV] = add_v;
      end
      FUNC_CMPIMM: begin
        rd  = {1'b0, hi8};
        val = sum[DataW-1:0];
        wr  = 1'b0;
        flags_next[FlagC] = sum[DataW];
        flags_next[FlagV] = add_v;
      end
      FUNC_LSL: begin
        rd  = {1'b0, lo0};
        val = lsl_ext[DataW-1:0];
        if (imm5 != 5'd0) begin
          flags_next[FlagC] = lsl_ext[DataW];
        end
      end
      FUNC_LSR: begin
        rd  = {1'b0, lo0};
        val = lsr_ext[DataW:1];
        flags_next[FlagC] = lsr_ext[0];
      end
      FUNC_MOVIMM: begin
        rd  = {1'b0, hi8};
        val = {24'd0, imm8};
      end
      FUNC_MOVHIGH: begin
        rd     = {w[7], lo0};
        val    = opa;
        set_nz = 1'b0;
      end
      default: begin
        wr     = 1'b0;
        set_nz = 1'b0;
      end
    endcase
    if (set_nz) begin
      flags_next[FlagN] = val[DataW-1];
      flags_next[FlagZ] = (val == '0);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (s1_move) begin
      result.dest_index     <= rd;
      result.dest_value     <= wr ? val : '0;
      result.wrote_register <= wr;
      result.flags_out      <= flags_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/tae_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tae_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module tae_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_a,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule
`default_nettype wire

// ===== sim/thumb_alu_execute_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// thumb_alu_execute_tb
// Self-checking bench for the Thumb ALU execute block. A directed table hits
// the edge cases: reset state, shift by zero and by 32, carry and overflow,
// SBC borrow-in, high-register moves through r15, and the no-op codes.
// Random instructions follow. Typed rows are checked against given values,
// all other beats against an in-bench model of register file and NZCV flags.
// The sender idles in bursts; the receiver stalls on a pattern of its own.
// ----------------------------------------------------------------------------
module thumb_alu_execute_tb;
  import tae_pkg::*;

  localparam logic [3:0] FUNC_NOP_FIRST = 4'd11;
  localparam logic [3:0] FUNC_NOP_LAST  = 4'd15;
  localparam int         RandCount      = 1500;
  localparam int         IdleLimit      = 200;
  localparam int         DrainCycles    = 8;
  localparam int         MaxReports     = 20;

  typedef struct {
    instr_t  ins;
    bit      typed;
    result_t exp;
  } beat_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    instr_valid = 1'b0;
  logic    instr_ready;
  instr_t  instr = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  thumb_alu_execute u_dut (
    .clk          (clk),
    .rst          (rst),
    .instr_valid  (instr_valid),
    .instr_ready  (instr_ready),
    .instr        (instr),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------- model
  logic [DataW-1:0] gpr [RegCount];
  logic [FlagW-1:0] nzcv;

  function automatic void set_nz(logic [31:0] v);
    nzcv[FlagN] = v[31];
    nzcv[FlagZ] = (v == 32'd0);
  endfunction

  function automatic logic [31:0] sub_nzcv(logic [31:0] a, logic [31:0] b, logic borrow);
    logic [32:0] wide;
    logic [31:0] r;
    wide = {1'b0, a} - {1'b0, b} - {32'd0, borrow};
    r = wide[31:0];
    set_nz(r);
    nzcv[FlagC] = ~wide[32];
    nzcv[FlagV] = (a[31] ^ b[31]) & (a[31] ^ r[31]);
    return r;
  endfunction

  function automatic logic [31:0] add_nzcv(logic [31:0] a, logic [31:0] b);
    logic [32:0] wide;
    logic [31:0] r;
    wide = {1'b0, a} + {1'b0, b};
    r = wide[31:0];
    set_nz(r);
    nzcv[FlagC] = wide[32];
    nzcv[FlagV] = ~(a[31] ^ b[31]) & (a[31] ^ r[31]);
    return r;
  endfunction

  function automatic result_t execute_thumb(instr_t ins);
    logic [15:0] w;
    logic [3:0]  lo0, lo3, lo6, hi8;
    logic [4:0]  imm5;
    logic [3:0]  rd;
    logic [31:0] val, m;
    logic        wr;
    result_t     r;
    w    = ins.opcode_halfword;
    lo0  = {1'b0, w[2:0]};
    lo3  = {1'b0, w[5:3]};
    lo6  = {1'b0, w[8:6]};
    hi8  = {1'b0, w[10:8]};
    imm5 = w[10:6];
    rd   = '0;
    val  = '0;
    wr   = 1'b1;
    case (ins.func)
      FUNC_BIC: begin
        rd  = lo0;
        val = gpr[lo0] & ~gpr[lo3];
        set_nz(val);
      end
      FUNC_SUBREG: begin
        rd  = lo0;
        val = sub_nzcv(gpr[lo3], gpr[lo6], 1'b0);
      end
      FUNC_SUBIMM: begin
        rd  = hi8;
        val = sub_nzcv(gpr[hi8], {24'd0, w[7:0]}, 1'b0);
      end
      FUNC_CMPIMM: begin
        rd = hi8;
        void'(sub_nzcv(gpr[hi8], {24'd0, w[7:0]}, 1'b0));
        wr = 1'b0;
      end
      FUNC_LSL: begin
        rd = lo0;
        m  = gpr[lo3];
        if (imm5 == 5'd0) begin
          val = m;
        end else begin
          nzcv[FlagC] = m[5'(6'd32 - {1'b0, imm5})];
          val = m << imm5;
        end
        set_nz(val);
      end
      FUNC_LSR: begin
        rd = lo0;
        m  = gpr[lo3];
        if (imm5 == 5'd0) begin
          nzcv[FlagC] = m[31];
          val = '0;
        end else begin
          nzcv[FlagC] = m[imm5 - 5'd1];
          val = m >> imm5;
        end
        set_nz(val);
      end
      FUNC_ADDREG: begin
        rd  = lo0;
        val = add_nzcv(gpr[lo3], gpr[lo6]);
      end
      FUNC_ADDIMM: begin
        rd  = lo0;
        val = add_nzcv(gpr[lo3], {28'd0, lo6});
      end
      FUNC_MOVIMM: begin
        rd  = hi8;
        val = {24'd0, w[7:0]};
        set_nz(val);
      end
      FUNC_MOVHIGH: begin
        rd  = {w[7], lo0[2:0]};
        val = gpr[w[6:3]];
      end
      FUNC_SBC: begin
        rd  = lo0;
        val = sub_nzcv(gpr[lo0], gpr[lo3], ~nzcv[FlagC]);
      end
      default: wr = 1'b0;
    endcase
    if (wr) begin
      gpr[rd] = val;
    end else begin
      val = '0;
    end
    r.dest_index     = rd;
    r.dest_value     = val;
    r.wrote_register = wr;
    r.flags_out      = nzcv;
    return r;
  endfunction

  // ------------------------------------------------------------ encoding
  function automatic logic [15:0] op_lo(int rd, int rn, int rm);
    return {7'd0, rm[2:0], rn[2:0], rd[2:0]};
  endfunction

  function automatic logic [15:0] op_imm8(int rd, int imm);
    return {5'd0, rd[2:0], imm[7:0]};
  endfunction

  function automatic logic [15:0] op_shift(int rd, int rm, int sh);
    return {5'd0, sh[4:0], rm[2:0], rd[2:0]};
  endfunction

  function automatic logic [15:0] op_high(int rd, int rm);
    return {8'd0, rd[3], rm[3:0], rd[2:0]};
  endfunction

  beat_t dir_tab[$];
  beat_t send_q[$];
  result_t expected_q[$];

  task automatic add_row(logic [3:0] f, logic [15:0] op, bit typed = 1'b0,
                         result_t exp = '0);
    beat_t b;
    b.ins.func = f;
    b.ins.opcode_halfword = op;
    b.typed = typed;
    b.exp = exp;
    dir_tab.push_back(b);
  endtask

  // --------------------------------------------------------------- sender
  beat_t cur_beat;
  int    gap_left = 0;
  int    burst_left = 0;
  int    n_issued = 0;
  int    n_nop = 0;

  always @(posedge clk) begin
    logic    nxt_valid;
    beat_t   nxt_beat;
    result_t got;
    if (rst) begin
      instr_valid <= 1'b0;
    end else begin
      nxt_valid = instr_valid;
      nxt_beat  = cur_beat;
      if (instr_valid && instr_ready) begin
        got = execute_thumb(cur_beat.ins);
        expected_q.push_back(cur_beat.typed ? cur_beat.exp : got);
        n_issued++;
        if (cur_beat.ins.func >= FUNC_NOP_FIRST) n_nop++;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (send_q.size() > 0) begin
          nxt_beat  = send_q.pop_front();
          nxt_valid = 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
      cur_beat    = nxt_beat;
      instr_valid <= nxt_valid;
      instr       <= nxt_beat.ins;
    end
  end

  // ------------------------------------------------------------- receiver
  logic [15:0] stall_pat = 16'hffff;
  logic [5:0]  stall_cnt = '0;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      stall_cnt <= stall_cnt + 6'd1;
      if (stall_cnt == 6'd0) begin
        stall_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff
                                                 : (16'($urandom()) | 16'h0101);
      end
      result_ready <= stall_pat[stall_cnt[3:0]];
    end
  end

  // -------------------------------------------------------------- checker
  int n_checked = 0;
  int n_errors = 0;

  always @(posedge clk) begin
    result_t exp;
    if (!rst && result_valid && result_ready) begin
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= MaxReports) begin
          $display("%0t: result beat with nothing expected: rd=%0d val=%h wr=%0b nzcv=%b",
                   $time, result.dest_index, result.dest_value,
                   result.wrote_register, result.flags_out);
        end
      end else begin
        exp = expected_q.pop_front();
        n_checked++;
        if (result !== exp) begin
          n_errors++;
          if (n_errors <= MaxReports) begin
            $display("%0t: mismatch: expected rd=%0d val=%h wr=%0b nzcv=%b",
                     $time, exp.dest_index, exp.dest_value, exp.wrote_register,
                     exp.flags_out);
            $display("%0t:           actual   rd=%0d val=%h wr=%0b nzcv=%b",
                     $time, result.dest_index, result.dest_value,
                     result.wrote_register, result.flags_out);
          end
        end
      end
    end
  end

  // ------------------------------------------------------------- watchdog
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if ((instr_valid && instr_ready) || (result_valid && result_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("%0t: no beat for %0d cycles", $time, IdleLimit);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ------------------------------------------------------------- stimulus
  initial begin
    beat_t b;
    for (int i = 0; i < RegCount; i++) gpr[i] = '0;
    nzcv = '0;

    // typed rows: NZCV written out as {N,Z,C,V}
    add_row(FUNC_CMPIMM, op_imm8(0, 8'h00), 1'b1, '{4'd0, 32'd0, 1'b0, 4'b0110});
    add_row(FUNC_MOVIMM, op_imm8(7, 8'hff), 1'b1, '{4'd7, 32'hff, 1'b1, 4'b0010});
    add_row(FUNC_NOP_LAST, 16'hffff, 1'b1, '{4'd0, 32'd0, 1'b0, 4'b0010});
    add_row(FUNC_SUBIMM, op_imm8(1, 8'h01), 1'b1, '{4'd1, 32'hffff_ffff, 1'b1, 4'b1000});
    add_row(FUNC_NOP_FIRST, 16'h0000, 1'b1, '{4'd0, 32'd0, 1'b0, 4'b1000});
    add_row(FUNC_LSL, op_shift(2, 1, 31));
    add_row(FUNC_LSL, op_shift(3, 1, 0));
    add_row(FUNC_LSR, op_shift(4, 1, 0));
    add_row(FUNC_LSR, op_shift(5, 2, 1));
    add_row(FUNC_LSR, op_shift(5, 1, 31));
    add_row(FUNC_ADDREG, op_lo(6, 1, 1));
    add_row(FUNC_ADDREG, op_lo(6, 2, 2));
    add_row(FUNC_ADDIMM, op_lo(0, 7, 7));
    add_row(FUNC_SUBREG, op_lo(3, 2, 1));
    add_row(FUNC_SUBREG, op_lo(3, 1, 1));
    add_row(FUNC_SUBIMM, op_imm8(7, 8'hff));
    add_row(FUNC_CMPIMM, op_imm8(1, 8'hff));
    add_row(FUNC_BIC, op_lo(7, 1, 0));
    add_row(FUNC_MOVHIGH, op_high(15, 1));
    add_row(FUNC_MOVHIGH, op_high(8, 15));
    add_row(FUNC_MOVHIGH, op_high(9, 8));
    add_row(FUNC_CMPIMM, op_imm8(0, 8'h01));
    add_row(FUNC_SBC, op_lo(1, 2, 0));
    add_row(FUNC_ADDREG, op_lo(6, 1, 1));
    add_row(FUNC_SBC, op_lo(2, 1, 0));

    foreach (dir_tab[i]) send_q.push_back(dir_tab[i]);

    // random part, leaning on MOV imm8 and shifts to keep register values varied
    for (int i = 0; i < RandCount; i++) begin
      b.typed = 1'b0;
      b.exp = '0;
      b.ins.opcode_halfword = 16'($urandom());
      case ($urandom_range(0, 9))
        0:       b.ins.func = 4'($urandom_range(FUNC_NOP_FIRST, FUNC_NOP_LAST));
        1:       b.ins.func = FUNC_MOVIMM;
        2:       b.ins.func = ($urandom_range(0, 1) == 0) ? FUNC_LSL : FUNC_LSR;
        default: b.ins.func = 4'($urandom_range(FUNC_BIC, FUNC_SBC));
      endcase
      send_q.push_back(b);
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (send_q.size() > 0 || instr_valid) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Issued %0d instructions (%0d directed, %0d random, %0d no-op codes).",
             n_issued, dir_tab.size(), RandCount, n_nop);
    $display("Checked %0d result beats, %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/tae_pkg.sv
hdl/tae_ram.sv
hdl/thumb_alu_execute.sv
sim/thumb_alu_execute_tb.sv
